// ===== hdl/decimal_digits_with_symbol_slot_defines.svh =====
// Assertion macros shared by the RTL of the decimal layout block.
// Standalone header, no dependencies.
`ifndef DECIMAL_DIGITS_WITH_SYMBOL_SLOT_DEFINES_SVH
`define DECIMAL_DIGITS_WITH_SYMBOL_SLOT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DDS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("dds assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define DDS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("dds assertion failed: next-cycle implication");

`endif

// ===== hdl/dds_pkg.sv =====
// Package for the decimal layout block: widths, codes and word types.
// No dependencies.
package dds_pkg;

    localparam int VALUE_W    = 32;
    localparam int MAG_W      = VALUE_W - 1;   // magnitude bits of a non-negative value
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;            // 2^31-1 has ten decimal digits
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int OUT_SLOTS  = 6;
    localparam int LEN_W      = 4;             // holds a digit count 0..10
    localparam int DD_STAGES  = 4;             // conversion pipeline depth

    // layout width, clamped to 1..MAX_DIGITS
    localparam int SLOT_COUNT_RAW = 6;
    localparam int SLOT_COUNT = (SLOT_COUNT_RAW < 1) ? 1 :
                                (SLOT_COUNT_RAW > MAX_DIGITS) ? MAX_DIGITS : SLOT_COUNT_RAW;

    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [BCD_W-1:0]     bcd_t;
    typedef logic [OUT_SLOTS-1:0] slot_mask_t;

    localparam digit_t BLANK_CODE = digit_t'(10);

endpackage

// ===== hdl/dds_in_if.sv =====
// Input channel of the decimal layout block: value and symbol request.
// Depends on dds_pkg.
interface dds_in_if
    import dds_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      show_symbol;

    modport source (output valid, output value, output show_symbol, input ready);
    modport sink   (input valid, input value, input show_symbol, output ready);
endinterface

// ===== hdl/dds_out_if.sv =====
// Output channel of the decimal layout block: six slots, symbol mask, invalid flag.
// Depends on dds_pkg.
interface dds_out_if
    import dds_pkg::*;
;
    logic       valid;
    logic       ready;
    digit_t     slot0;
    digit_t     slot1;
    digit_t     slot2;
    digit_t     slot3;
    digit_t     slot4;
    digit_t     slot5;
    slot_mask_t symbol_mask;
    logic       invalid;

    modport source (output valid, output slot0, output slot1, output slot2, output slot3,
                    output slot4, output slot5, output symbol_mask, output invalid,
                    input ready);
    modport sink   (input valid, input slot0, input slot1, input slot2, input slot3,
                    input slot4, input slot5, input symbol_mask, input invalid,
                    output ready);
endinterface

// ===== hdl/decimal_digits_with_symbol_slot.sv =====
// Decimal layout with leading blanking and a symbol slot. Each word on value_ch
// carries a signed 32-bit value and a show_symbol bit; the matching word on
// layout_ch holds six display slots (slot0 leftmost, codes 0-9 digits, 10 blank),
// a one-hot symbol_mask and an invalid flag. A non-negative value is right
// aligned with blank leading slots; values with six or more digits show their
// low six digits and no symbol; shorter values with show_symbol set mark the
// blank slot just left of the first digit. A negative value gives an all-blank
// layout with invalid set. Throughput is one word per clock while the receiver
// keeps ready high; the accepting edge loads the first of four double-dabble
// stages (eight shift/add-3 steps each, seven in the last), and the layout logic
// behind the last stage feeds the output register that drives layout_ch.
// Each stage carries its own valid bit and holds its word only while it is full
// and the stage after it cannot take it, so bubbles are squeezed out under
// back-pressure and nothing is dropped or repeated. Depends on dds_pkg,
// dds_in_if, dds_out_if and the defines header.
`include "decimal_digits_with_symbol_slot_defines.svh"

module decimal_digits_with_symbol_slot
    import dds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dds_in_if.sink    value_ch,
    dds_out_if.source layout_ch
);

    localparam int STEPS_PER_STAGE = (MAG_W + DD_STAGES - 1) / DD_STAGES;
    localparam int LAST = DD_STAGES - 1;

    // one double-dabble step: add 3 to every digit >= 5, then shift in a bit
    function automatic bcd_t dd_step(bcd_t bcd, logic bit_in);
        bcd_t t;
        t = bcd;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (t[d*DIGIT_W +: DIGIT_W] >= digit_t'(5))
                t[d*DIGIT_W +: DIGIT_W] = t[d*DIGIT_W +: DIGIT_W] + digit_t'(3);
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic bcd_is_decimal(bcd_t bcd);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd[d*DIGIT_W +: DIGIT_W] > digit_t'(9))
                ok = 1'b0;
        end
        return ok;
    endfunction

    // conversion pipeline registers
    logic             valid_reg [DD_STAGES];
    logic [MAG_W-1:0] bin_reg   [DD_STAGES];
    bcd_t             bcd_reg   [DD_STAGES];
    logic             sym_reg   [DD_STAGES];
    logic             neg_reg   [DD_STAGES];

    // output register
    logic       out_valid_reg;
    digit_t     slot_reg [OUT_SLOTS];
    slot_mask_t mask_reg;
    logic       inval_reg;

    // adv[k]: stage k may load this cycle; adv[DD_STAGES] is the output register
    logic [DD_STAGES:0] adv;

    always_comb
    begin
        adv[DD_STAGES] = !out_valid_reg || layout_ch.ready;
        for (int k = LAST; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign value_ch.ready = adv[0];

    // double-dabble stages
    for (genvar k = 0; k < DD_STAGES; k++) begin : g_stage
        logic             src_valid;
        logic [MAG_W-1:0] src_bin;
        bcd_t             src_bcd;
        logic             src_sym;
        logic             src_neg;
        logic [MAG_W-1:0] bin_next;
        bcd_t             bcd_next;

        if (k == 0) begin : g_head
            assign src_valid = value_ch.valid;
            assign src_bin   = value_ch.value[MAG_W-1:0];
            assign src_bcd   = '0;
            assign src_sym   = value_ch.show_symbol;
            assign src_neg   = value_ch.value[VALUE_W-1];
        end else begin : g_body
            assign src_valid = valid_reg[k-1];
            assign src_bin   = bin_reg[k-1];
            assign src_bcd   = bcd_reg[k-1];
            assign src_sym   = sym_reg[k-1];
            assign src_neg   = neg_reg[k-1];
        end

        always_comb
        begin
            bin_next = src_bin;
            bcd_next = src_bcd;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (k * STEPS_PER_STAGE + j < MAG_W) begin
                    bcd_next = dd_step(bcd_next, bin_next[MAG_W-1]);
                    bin_next = {bin_next[MAG_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv[k])
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                bin_reg[k] <= bin_next;
                bcd_reg[k] <= bcd_next;
                sym_reg[k] <= src_sym;
                neg_reg[k] <= src_neg;
            end
        end
    end

    // layout stage: digit count, right alignment, blanking, symbol slot
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pad_m1;
    digit_t           slot_next [OUT_SLOTS];
    slot_mask_t       mask_next;

    always_comb
    begin
        len = LEN_W'(1);   // zero still shows one digit
        for (int d = 1; d < MAX_DIGITS; d++) begin
            if (bcd_reg[LAST][d*DIGIT_W +: DIGIT_W] != '0)
                len = LEN_W'(d + 1);
        end

        for (int i = 0; i < OUT_SLOTS; i++) begin
            slot_next[i] = BLANK_CODE;
            if (i < SLOT_COUNT && !neg_reg[LAST]) begin
                if (LEN_W'(SLOT_COUNT - 1 - i) < len)
                    slot_next[i] = bcd_reg[LAST][(SLOT_COUNT-1-i)*DIGIT_W +: DIGIT_W];
            end
        end

        // blank slot just left of the leading digit
        pad_m1    = LEN_W'(SLOT_COUNT) - len - LEN_W'(1);
        mask_next = '0;
        if (!neg_reg[LAST] && sym_reg[LAST] && len < LEN_W'(SLOT_COUNT)) begin
            for (int i = 0; i < OUT_SLOTS; i++) begin
                mask_next[i] = (pad_m1 == LEN_W'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv[DD_STAGES])
            out_valid_reg <= valid_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (adv[DD_STAGES])
        begin
            for (int i = 0; i < OUT_SLOTS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
            mask_reg  <= mask_next;
            inval_reg <= neg_reg[LAST];
        end
    end

    assign layout_ch.valid       = out_valid_reg;
    assign layout_ch.slot0       = slot_reg[0];
    assign layout_ch.slot1       = slot_reg[1];
    assign layout_ch.slot2       = slot_reg[2];
    assign layout_ch.slot3       = slot_reg[3];
    assign layout_ch.slot4       = slot_reg[4];
    assign layout_ch.slot5       = slot_reg[5];
    assign layout_ch.symbol_mask = mask_reg;
    assign layout_ch.invalid     = inval_reg;

    // negative input must come out with no symbol and blank end slots (slot0, slot5)
    `DDS_ASSERT_IMPL(a_invalid_blank, clk, rst_n, layout_ch.valid && layout_ch.invalid,
        layout_ch.symbol_mask == '0 && slot_reg[5] == BLANK_CODE && slot_reg[0] == BLANK_CODE)
    // at most one symbol slot
    `DDS_ASSERT_IMPL(a_mask_onehot, clk, rst_n, layout_ch.valid, $onehot0(layout_ch.symbol_mask))
    // last conversion stage holds its word while the output register is full
    `DDS_ASSERT_NEXT(a_last_hold, clk, rst_n, valid_reg[LAST] && !adv[DD_STAGES],
        valid_reg[LAST] && $stable(bcd_reg[LAST]))
    // finished conversion holds only decimal digits
    `DDS_ASSERT_IMPL(a_bcd_decimal, clk, rst_n, valid_reg[LAST], bcd_is_decimal(bcd_reg[LAST]))

endmodule

// ===== dv/layout_checker.sv =====
// Scoreboard for the decimal layout block: watches both channels, predicts each layout word.
// Depends on dds_pkg, dds_in_if and dds_out_if.
module layout_checker
    import dds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic drain_done,
    dds_in_if    value_ch,
    dds_out_if   layout_ch,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        digit_t [OUT_SLOTS-1:0] slot;
        slot_mask_t             symbol_mask;
        logic                   invalid;
    } layout_word_t;

    layout_word_t expected_layouts[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Right-aligned decimal digits, blank lead, symbol just left of the first digit.
    function automatic layout_word_t predict_layout(input logic signed [VALUE_W-1:0] value,
                                                    input logic show_symbol);
        digit_t        digs [MAX_DIGITS];
        digit_t        cells[MAX_DIGITS];
        logic [MAG_W-1:0] mag;
        int            len;
        int            pad;
        layout_word_t  w;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digs[i]  = '0;
            cells[i] = BLANK_CODE;
        end
        w.symbol_mask = '0;
        w.invalid     = 1'b0;
        if (value[VALUE_W-1])
        begin
            w.invalid = 1'b1;
        end
        else
        begin
            mag = value[MAG_W-1:0];
            len = 0;
            do
            begin
                if (len < MAX_DIGITS)
                    digs[len] = digit_t'(mag % 10);
                len++;
                mag = MAG_W'(mag / 10);
            end while (mag != 0);
            if (len >= SLOT_COUNT)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    cells[i] = digs[SLOT_COUNT-1-i];
            end
            else
            begin
                pad = SLOT_COUNT - len;
                for (int i = pad; i < SLOT_COUNT; i++)
                    cells[i] = digs[SLOT_COUNT-1-i];
                if (show_symbol && (pad - 1) < OUT_SLOTS)
                    w.symbol_mask = slot_mask_t'(1) << (pad - 1);
            end
        end
        for (int i = 0; i < OUT_SLOTS; i++)
            w.slot[i] = cells[i];
        return w;
    endfunction

    always @(posedge clk)
    begin
        layout_word_t got;
        layout_word_t want;
        if (rst_n)
        begin
            if (value_ch.valid && value_ch.ready)
                expected_layouts.push_back(predict_layout(value_ch.value, value_ch.show_symbol));
            if (layout_ch.valid && layout_ch.ready)
            begin
                got.slot[0]     = layout_ch.slot0;
                got.slot[1]     = layout_ch.slot1;
                got.slot[2]     = layout_ch.slot2;
                got.slot[3]     = layout_ch.slot3;
                got.slot[4]     = layout_ch.slot4;
                got.slot[5]     = layout_ch.slot5;
                got.symbol_mask = layout_ch.symbol_mask;
                got.invalid     = layout_ch.invalid;
                if (expected_layouts.size() == 0)
                begin
                    report_mismatch("layout word with none pending", int'(got), -1);
                end
                else
                begin
                    want = expected_layouts.pop_front();
                    for (int i = 0; i < OUT_SLOTS; i++)
                        if (got.slot[i] !== want.slot[i])
                            report_mismatch($sformatf("slot%0d", i), int'(got.slot[i]),
                                            int'(want.slot[i]));
                    if (got.symbol_mask !== want.symbol_mask)
                        report_mismatch("symbol_mask", int'(got.symbol_mask),
                                        int'(want.symbol_mask));
                    if (got.invalid !== want.invalid)
                        report_mismatch("invalid", int'(got.invalid), int'(want.invalid));
                end
            end
            pending = expected_layouts.size();
        end
    end

    always @(posedge drain_done)
    begin
        if (expected_layouts.size() != 0)
            report_mismatch("layout words never delivered", expected_layouts.size(), 0);
    end

endmodule

// ===== dv/tb.sv =====
// Top of the decimal layout testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on dds_pkg, dds_in_if, dds_out_if, layout_checker and the block itself.
module tb
    import dds_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD   = 10;
    localparam int  RESET_CYCLES = 12;
    localparam int  WORDS_PER_PHASE = 200;
    localparam int  HOLD_CYCLES  = 80;    // long receiver hold-off, fills the pipe
    localparam int  PRESSURE_WORDS = 40;
    localparam int  DRAIN_CYCLES = 20;
    localparam time TIMEOUT_NS   = 2_000_000;

    logic clk;
    logic rst_n;
    logic drain_done;
    int   fail_count;
    int   pending;

    // Idle/stall odds in percent, set per phase by the stimulus process.
    int   sender_idle_pct;
    int   recv_stall_pct;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int   hold_requests;

    dds_in_if  value_ch();
    dds_out_if layout_ch();

    decimal_digits_with_symbol_slot uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_ch  (value_ch),
        .layout_ch (layout_ch)
    );

    layout_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .drain_done (drain_done),
        .value_ch   (value_ch),
        .layout_ch  (layout_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD/2) clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one word; idle gaps come first, then hold valid until it is taken.
    // Inputs move only at the falling edge.
    task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic sym);
        @(negedge clk);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            value_ch.valid <= 1'b0;
            @(negedge clk);
        end
        value_ch.valid       <= 1'b1;
        value_ch.value       <= v;
        value_ch.show_symbol <= sym;
        do
            @(posedge clk);
        while (!value_ch.ready);
    endtask

    // Pick a digit count first so short numbers (symbol slot cases) are as
    // common as long ones; a tenth of the words are negative.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned lo;
        int unsigned hi;
        int          len;
        if ($urandom_range(9, 0) == 0)
            return {1'b1, MAG_W'($urandom)};
        len = $urandom_range(MAX_DIGITS, 1);
        lo  = 1;
        repeat (len - 1) lo = lo * 10;
        hi  = (len == MAX_DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (len == 1)
            lo = 0;
        return $urandom_range(hi, lo);
    endfunction

    task automatic run_phase(input int words, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (words)
            send_value(random_value(), 1'($urandom));
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        layout_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                layout_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                layout_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        drain_done           = 1'b0;
        sender_idle_pct      = 0;
        recv_stall_pct       = 0;
        hold_requests        = 0;
        value_ch.valid       <= 1'b0;
        value_ch.value       <= '0;
        value_ch.show_symbol <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero, digit counts one to seven, nine and ten, the six-digit boundary where the
        // symbol disappears, truncation to the low digits, and negatives.
        send_value(0, 1'b0);
        send_value(0, 1'b1);
        send_value(9, 1'b1);
        send_value(10, 1'b0);
        send_value(99, 1'b1);
        send_value(999, 1'b1);
        send_value(9999, 1'b0);
        send_value(12345, 1'b1);    // symbol lands in the leftmost slot
        send_value(99999, 1'b0);
        send_value(100000, 1'b1);   // exactly six digits: no symbol
        send_value(999999, 1'b1);
        send_value(1000000, 1'b1);  // seven digits: low six shown
        send_value(123456789, 1'b0);
        send_value(1000000000, 1'b1);
        send_value(32'sh7FFF_FFFF, 1'b1);
        send_value(32'sh7FFF_FFFF, 1'b0);
        send_value(-1, 1'b1);
        send_value(-1, 1'b0);
        send_value(32'sh8000_0000, 1'b1);
        send_value(32'shAAAA_AAAA, 1'b0);
        send_value(32'sh5555_5555, 1'b1);
        send_value(7, 1'b0);

        // Random phases: free flow, sparse sender, slow receiver, both.
        run_phase(WORDS_PER_PHASE, 0, 0);
        run_phase(WORDS_PER_PHASE, 79, 0);
        run_phase(WORDS_PER_PHASE, 0, 79);
        run_phase(WORDS_PER_PHASE, 38, 38);

        // Back-pressure: receiver holds off while words keep coming.
        hold_requests++;
        run_phase(PRESSURE_WORDS, 0, 0);

        @(negedge clk);
        value_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        drain_done = 1'b1;
        @(posedge clk);
        #1;
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
